### sv/four_lane_dot_product_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-lane dot product core
// Shared property wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef FOUR_LANE_DOT_PRODUCT_CORE_MACROS_SVH
`define FOUR_LANE_DOT_PRODUCT_CORE_MACROS_SVH

// same-cycle implication
`define FLDP_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("fldp same-cycle check failed");

// next-cycle implication
`define FLDP_ASSERT_NXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("fldp next-cycle check failed");

`endif

### sv/fldp_pkg.sv
// ----------------------------------------------------------------------------
// fldp_pkg
// Widths, types and limits shared by the four-lane dot product core.
// ----------------------------------------------------------------------------
package fldp_pkg;

  localparam int LANES  = 4;
  localparam int OP_W   = 16;
  localparam int PROD_W = 2 * OP_W;
  localparam int TREE_W = PROD_W + $clog2(LANES);
  localparam int ACC_W  = 48;
  localparam int SUM_W  = ACC_W + 1;

  typedef logic signed [OP_W-1:0]   op_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [TREE_W-1:0] tree_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [SUM_W-1:0]  wide_sum_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic  valid;
    logic  last;
    tree_t sum;
  } tree_word_t;

endpackage

### sv/fldp_ifs.sv
// ----------------------------------------------------------------------------
// fldp channel interfaces
// Operand channel (four lane pairs plus end-of-vector flag) and result channel.
// ----------------------------------------------------------------------------
interface fldp_in_if;
  logic          valid;
  logic          ready;
  fldp_pkg::op_t a_lane0;
  fldp_pkg::op_t a_lane1;
  fldp_pkg::op_t a_lane2;
  fldp_pkg::op_t a_lane3;
  fldp_pkg::op_t b_lane0;
  fldp_pkg::op_t b_lane1;
  fldp_pkg::op_t b_lane2;
  fldp_pkg::op_t b_lane3;
  logic          last_group;

  modport source (
    output valid, a_lane0, a_lane1, a_lane2, a_lane3,
    output b_lane0, b_lane1, b_lane2, b_lane3, last_group,
    input  ready
  );
  modport sink (
    input  valid, a_lane0, a_lane1, a_lane2, a_lane3,
    input  b_lane0, b_lane1, b_lane2, b_lane3, last_group,
    output ready
  );
endinterface

interface fldp_out_if;
  logic           valid;
  logic           ready;
  fldp_pkg::acc_t dot_sum;
  logic           overflowed;

  modport source (output valid, dot_sum, overflowed, input ready);
  modport sink (input valid, dot_sum, overflowed, output ready);
endinterface

### sv/fldp_lane.sv
// ----------------------------------------------------------------------------
// fldp_lane
// One multiply lane: registered signed Q8.8 x Q8.8 product in Q16.16.
// ----------------------------------------------------------------------------
module fldp_lane (
  input  logic            clk,
  input  logic            en,
  input  fldp_pkg::op_t   a,
  input  fldp_pkg::op_t   b,
  output fldp_pkg::prod_t prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * b;
    end
  end

endmodule

### sv/fldp_merge.sv
// ----------------------------------------------------------------------------
// fldp_merge
// Adder tree over the lane products, registered with the word's control bits.
// ----------------------------------------------------------------------------
module fldp_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 prod_valid,
  input  logic                 prod_last,
  input  fldp_pkg::prod_t      prods [fldp_pkg::LANES],
  output fldp_pkg::tree_word_t word
);

  fldp_pkg::tree_t pair_lo;
  fldp_pkg::tree_t pair_hi;

  assign pair_lo = fldp_pkg::TREE_W'(prods[0]) + fldp_pkg::TREE_W'(prods[1]);
  assign pair_hi = fldp_pkg::TREE_W'(prods[2]) + fldp_pkg::TREE_W'(prods[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else if (en) begin
      word.valid <= prod_valid;
    end
    if (en) begin
      word.last <= prod_last;
      word.sum  <= pair_lo + pair_hi;
    end
  end

endmodule

### sv/fldp_acc.sv
// ----------------------------------------------------------------------------
// fldp_acc
// Saturating 48-bit accumulator with overflow flag and result output register.
// ----------------------------------------------------------------------------
`include "four_lane_dot_product_core_macros.svh"

module fldp_acc (
  input  logic                 clk,
  input  logic                 rst,
  input  fldp_pkg::tree_word_t word,
  output logic                 stall,
  fldp_out_if.source           res
);

  fldp_pkg::acc_t      running_sum;
  logic                saturated_flag;
  fldp_pkg::wide_sum_t sum_full;
  fldp_pkg::acc_t      sum_sat;
  logic                sat_hit;
  logic                take;
  logic                take_last;
  logic                res_valid;

  assign stall     = word.valid & word.last & res_valid & ~res.ready;
  assign take      = word.valid & ~stall;
  assign take_last = take & word.last;

  assign sum_full = fldp_pkg::SUM_W'(running_sum) + fldp_pkg::SUM_W'(word.sum);
  assign sat_hit  = sum_full[fldp_pkg::SUM_W-1] != sum_full[fldp_pkg::ACC_W-1];

  always_comb begin
    if (!sat_hit) begin
      sum_sat = sum_full[fldp_pkg::ACC_W-1:0];
    end else if (sum_full[fldp_pkg::SUM_W-1]) begin
      sum_sat = fldp_pkg::ACC_MIN;
    end else begin
      sum_sat = fldp_pkg::ACC_MAX;
    end
  end

  // accumulate, clear at end of vector
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum    <= '0;
      saturated_flag <= 1'b0;
    end else if (take_last) begin
      running_sum    <= '0;
      saturated_flag <= 1'b0;
    end else if (take) begin
      running_sum    <= sum_sat;
      saturated_flag <= saturated_flag | sat_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take_last) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      res.dot_sum    <= sum_sat;
      res.overflowed <= saturated_flag | sat_hit;
    end
  end

  assign res.valid = res_valid;

  `FLDP_ASSERT_NXT(a_clear_after_last, take_last, running_sum == '0 && !saturated_flag)
  `FLDP_ASSERT_NXT(a_result_loaded, take_last, res_valid)
  `FLDP_ASSERT_NXT(a_flag_on_clamp, take && !word.last && sat_hit, saturated_flag)
  `FLDP_ASSERT_IMP(a_stall_only_full, stall, res_valid && word.valid)

endmodule

### sv/four_lane_dot_product_core.sv
// ----------------------------------------------------------------------------
// four_lane_dot_product_core
// Streaming four-lane multiply-accumulate dot product, signed Q8.8 in,
// saturated signed Q32.16 out.
//
// ops carries one group per word: four a/b lane pairs and last_group. A vector
// is one or more words, the final one flagged last_group; a short tail group
// has its unused lanes at zero. res carries one word per vector: dot_sum and
// overflowed, set when the 48-bit accumulator clamped in that vector.
// Throughput is one group per cycle while the pipeline is not stalled; the
// only cross-word dependency is the single accumulator add.
// The multiply lanes load at the accepting edge, then the adder tree register,
// then the accumulator and the result register; res.valid is set by the
// accumulator stage when it takes the last group of a vector.
// Reset clears the pipeline valid bits, the accumulator and the overflow flag.
// A stalled receiver holds the result register; groups keep flowing until a
// second finished vector reaches the accumulator, which then holds the whole
// pipeline and drops ops.ready until res is taken.
// ----------------------------------------------------------------------------
module four_lane_dot_product_core (
  input  logic       clk,
  input  logic       rst,
  fldp_in_if.sink    ops,
  fldp_out_if.source res
);

  fldp_pkg::op_t        a_arr [fldp_pkg::LANES];
  fldp_pkg::op_t        b_arr [fldp_pkg::LANES];
  fldp_pkg::prod_t      prods [fldp_pkg::LANES];
  fldp_pkg::tree_word_t word;
  logic                 stall;
  logic                 advance;
  logic                 prod_valid;
  logic                 prod_last;

  assign a_arr[0] = ops.a_lane0;
  assign a_arr[1] = ops.a_lane1;
  assign a_arr[2] = ops.a_lane2;
  assign a_arr[3] = ops.a_lane3;
  assign b_arr[0] = ops.b_lane0;
  assign b_arr[1] = ops.b_lane1;
  assign b_arr[2] = ops.b_lane2;
  assign b_arr[3] = ops.b_lane3;

  assign advance   = ~stall;
  assign ops.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (advance) begin
      prod_valid <= ops.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_last <= ops.last_group;
    end
  end

  for (genvar i = 0; i < fldp_pkg::LANES; i++) begin : g_lane
    fldp_lane u_lane (
      .clk  (clk),
      .en   (advance),
      .a    (a_arr[i]),
      .b    (b_arr[i]),
      .prod (prods[i])
    );
  end

  fldp_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .prod_valid (prod_valid),
    .prod_last  (prod_last),
    .prods      (prods),
    .word       (word)
  );

  fldp_acc u_acc (
    .clk   (clk),
    .rst   (rst),
    .word  (word),
    .stall (stall),
    .res   (res)
  );

endmodule
